FILE: design/bhrc_pkg.sv
// ----------------------------------------------------------------------------
// bhrc_pkg: shared definitions for the banded heater relay control core
// Widths, conversion constants, band and register codes, and the beat
// structures passed between the averager, converter and relay control.
// ----------------------------------------------------------------------------
package bhrc_pkg;

    // Moving-average ring; depth must be a power of two (average is a shift)
    localparam int AVERAGE_DEPTH = 16;
    localparam int AVG_SHIFT     = $clog2(AVERAGE_DEPTH);
    localparam int SLOT_W        = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;

    localparam int SAMPLE_W = 10;
    localparam int SUM_W    = SAMPLE_W + AVG_SHIFT;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int TARGET_W = 13;
    localparam int TEMP_W   = 15;
    localparam int CFG_W    = 16;
    localparam int INDEX_W  = 2;

    // Sensor conversion: T = trunc0((avg*5000 - 409200) * 128 / 39897)
    localparam int OFFS_W      = 23;
    localparam int ADC_SCALE   = 5000;
    localparam int ADC_OFFSET  = 409200;
    localparam int CONV_DIV    = 39897;
    localparam int CONV_PRE    = 7;
    localparam int CONV_K      = 46;
    localparam int RECIP_W     = 31;
    localparam int CONV_PROD_W = OFFS_W + RECIP_W;
    localparam longint unsigned CONV_RECIP_L =
        ((64'd1 << CONV_K) + CONV_DIV - 1) / CONV_DIV;
    localparam logic [RECIP_W-1:0] CONV_RECIP = CONV_RECIP_L[RECIP_W-1:0];
    localparam int CONV_DROP = CONV_K - CONV_PRE;

    // Band edges and rules, in 1/64 degC
    localparam int OFFSET_FAR   = 640;
    localparam int OFFSET_NEAR  = 256;
    localparam int OFFSET_HOLD  = 128;
    localparam int RISE_MIN     = 64;
    localparam int TARGET_LOW   = 1280;
    localparam int TARGET_HIGH  = 5120;
    localparam logic signed [15:0] TEMP_RESET = -16'sd1312;

    localparam logic [PERIOD_W-1:0] FAR_PERIOD_RESET  = 16'd10000;
    localparam logic [PERIOD_W-1:0] NEAR_PERIOD_RESET = 16'd8000;
    localparam logic [PERIOD_W-1:0] HOLD_PERIOD_RESET = 16'd5000;

    typedef enum logic [2:0] {
        BAND_ABOVE = 3'd0,
        BAND_COLD  = 3'd1,
        BAND_FAR   = 3'd2,
        BAND_NEAR  = 3'd3,
        BAND_HOLD  = 3'd4
    } band_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_TARGET = 2'd0,
        REG_FAR    = 2'd1,
        REG_NEAR   = 2'd2,
        REG_HOLD   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [PERIOD_W-1:0] far_period;
        logic [PERIOD_W-1:0] near_period;
        logic [PERIOD_W-1:0] hold_period;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] avg;
        logic [TIME_W-1:0]   now;
    } avg_beat_t;

    typedef struct packed {
        logic              neg;
        logic [OFFS_W-1:0] offs;
        logic [TIME_W-1:0] now;
    } offs_beat_t;

    typedef struct packed {
        logic              neg;
        logic [TEMP_W-1:0] mag;
        logic [TIME_W-1:0] now;
    } temp_beat_t;

endpackage

FILE: design/bhrc_ram.sv
// ----------------------------------------------------------------------------
// bhrc_ram: generic single-write, single-read synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bhrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/bhrc_avg.sv
// ----------------------------------------------------------------------------
// bhrc_avg: ring-buffer moving average
// Reads the oldest sample from the ring RAM, updates the running sum and
// writes the new sample back; entries never written read as zero.
// ----------------------------------------------------------------------------
module bhrc_avg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              accept,
    input  logic [bhrc_pkg::SAMPLE_W-1:0]     adc_sample,
    input  logic [bhrc_pkg::TIME_W-1:0]       now_ms,
    output logic                              avg_valid,
    output bhrc_pkg::avg_beat_t               avg_beat
);

    logic [bhrc_pkg::SLOT_W-1:0]        slot_reg;
    logic [bhrc_pkg::SLOT_W-1:0]        slot_next;
    logic [bhrc_pkg::SUM_W-1:0]         sum_reg;
    logic [bhrc_pkg::SUM_W-1:0]         sum_next;
    logic [bhrc_pkg::AVERAGE_DEPTH-1:0] filled_reg;

    logic                               r1_valid_reg;
    logic [bhrc_pkg::SAMPLE_W-1:0]      r1_sample_reg;
    logic [bhrc_pkg::TIME_W-1:0]        r1_now_reg;
    logic [bhrc_pkg::SLOT_W-1:0]        r1_slot_reg;
    logic                               r1_filled_reg;
    logic                               r1_fwd_reg;
    logic [bhrc_pkg::SAMPLE_W-1:0]      r1_fwd_data_reg;

    logic                               avg_valid_reg;
    bhrc_pkg::avg_beat_t                avg_beat_reg;

    logic                               wr_en;
    logic                               fwd_hit;
    logic [bhrc_pkg::SAMPLE_W-1:0]      ram_rdata;
    logic [bhrc_pkg::SAMPLE_W-1:0]      old_sample;

    bhrc_ram #(
        .WIDTH (bhrc_pkg::SAMPLE_W),
        .DEPTH (bhrc_pkg::AVERAGE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (wr_en),
        .waddr (r1_slot_reg),
        .wdata (r1_sample_reg),
        .re    (accept),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // Write back the stage-1 sample; forward it if the new read hits it
    assign wr_en   = advance && r1_valid_reg;
    assign fwd_hit = wr_en && (r1_slot_reg == slot_reg);

    always_comb
    begin
        if (r1_fwd_reg)
            old_sample = r1_fwd_data_reg;
        else if (r1_filled_reg)
            old_sample = ram_rdata;
        else
            old_sample = '0;
        sum_next = sum_reg - bhrc_pkg::SUM_W'(old_sample)
                           + bhrc_pkg::SUM_W'(r1_sample_reg);
        if (slot_reg == bhrc_pkg::SLOT_W'(bhrc_pkg::AVERAGE_DEPTH - 1))
            slot_next = '0;
        else
            slot_next = slot_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            sum_reg       <= '0;
            filled_reg    <= '0;
            r1_valid_reg  <= 1'b0;
            avg_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                slot_reg <= slot_next;
            if (wr_en)
            begin
                sum_reg                  <= sum_next;
                filled_reg[r1_slot_reg]  <= 1'b1;
            end
            if (advance)
            begin
                r1_valid_reg  <= accept;
                avg_valid_reg <= r1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            r1_sample_reg   <= adc_sample;
            r1_now_reg      <= now_ms;
            r1_slot_reg     <= slot_reg;
            r1_filled_reg   <= filled_reg[slot_reg];
            r1_fwd_reg      <= fwd_hit;
            r1_fwd_data_reg <= r1_sample_reg;
        end
        if (wr_en)
        begin
            avg_beat_reg.avg <= sum_next[bhrc_pkg::SUM_W-1 -: bhrc_pkg::SAMPLE_W];
            avg_beat_reg.now <= r1_now_reg;
        end
    end

    assign avg_valid = avg_valid_reg;
    assign avg_beat  = avg_beat_reg;

endmodule

FILE: design/bhrc_conv.sv
// ----------------------------------------------------------------------------
// bhrc_conv: average-to-temperature conversion
// Two stages: scale and offset, then a reciprocal multiply that divides
// the magnitude by 39897/128 exactly (truncation toward zero).
// ----------------------------------------------------------------------------
module bhrc_conv (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   avg_valid,
    input  bhrc_pkg::avg_beat_t    avg_beat,
    output logic                   temp_valid,
    output bhrc_pkg::temp_beat_t   temp_beat
);

    logic [bhrc_pkg::OFFS_W-1:0]      scaled;
    logic                             below;
    logic                             c1_valid_reg;
    bhrc_pkg::offs_beat_t             c1_beat_reg;
    logic [bhrc_pkg::CONV_PROD_W-1:0] prod;
    logic                             c2_valid_reg;
    bhrc_pkg::temp_beat_t             c2_beat_reg;

    // Scale and offset; keep the sign apart so the divide works on a magnitude
    always_comb
    begin
        scaled = bhrc_pkg::OFFS_W'(avg_beat.avg) * bhrc_pkg::OFFS_W'(bhrc_pkg::ADC_SCALE);
        below  = scaled < bhrc_pkg::OFFS_W'(bhrc_pkg::ADC_OFFSET);
        prod   = bhrc_pkg::CONV_PROD_W'(c1_beat_reg.offs)
               * bhrc_pkg::CONV_PROD_W'(bhrc_pkg::CONV_RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            c1_valid_reg <= avg_valid;
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c1_beat_reg.neg  <= below;
            c1_beat_reg.offs <= below
                ? bhrc_pkg::OFFS_W'(bhrc_pkg::ADC_OFFSET) - scaled
                : scaled - bhrc_pkg::OFFS_W'(bhrc_pkg::ADC_OFFSET);
            c1_beat_reg.now  <= avg_beat.now;
            c2_beat_reg.neg  <= c1_beat_reg.neg;
            c2_beat_reg.mag  <= prod[bhrc_pkg::CONV_DROP +: bhrc_pkg::TEMP_W];
            c2_beat_reg.now  <= c1_beat_reg.now;
        end
    end

    assign temp_valid = c2_valid_reg;
    assign temp_beat  = c2_beat_reg;

endmodule

FILE: design/bhrc_ctrl.sv
// ----------------------------------------------------------------------------
// bhrc_ctrl: band decision and relay state
// Classifies the temperature against the target, runs the timed rise check
// in the near bands and registers the result beat.
// ----------------------------------------------------------------------------
module bhrc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          temp_valid,
    input  bhrc_pkg::temp_beat_t          temp_beat,
    input  bhrc_pkg::cfg_t                cfg,
    output logic                          result_valid,
    output logic                          relay_on,
    output logic [2:0]                    band,
    output logic [bhrc_pkg::TEMP_W-1:0]   temperature
);

    logic                             relay_reg;
    logic                             relay_next;
    logic signed [15:0]               prev_temp_reg;
    logic signed [15:0]               prev_temp_next;
    logic [bhrc_pkg::TIME_W-1:0]      last_check_reg;
    logic [bhrc_pkg::TIME_W-1:0]      last_check_next;

    logic                             result_valid_reg;
    logic [2:0]                       band_reg;
    logic [bhrc_pkg::TEMP_W-1:0]      temp_reg;

    logic signed [15:0]               t_mag;
    logic signed [15:0]               t_val;
    logic signed [15:0]               set_point;
    logic signed [16:0]               rise;
    logic [bhrc_pkg::TIME_W-1:0]      elapsed;
    logic [bhrc_pkg::PERIOD_W-1:0]    period;
    logic                             check_due;
    bhrc_pkg::band_t                  band_sel;

    always_comb
    begin
        t_mag     = signed'({1'b0, temp_beat.mag});
        t_val     = temp_beat.neg ? -t_mag : t_mag;
        set_point = signed'(16'(cfg.target));
        rise      = 17'(t_val) - 17'(prev_temp_reg);
        elapsed   = temp_beat.now - last_check_reg;

        if (t_val >= set_point)
            band_sel = bhrc_pkg::BAND_ABOVE;
        else if (t_val < set_point - 16'(bhrc_pkg::OFFSET_FAR))
            band_sel = bhrc_pkg::BAND_COLD;
        else if (t_val < set_point - 16'(bhrc_pkg::OFFSET_NEAR))
            band_sel = bhrc_pkg::BAND_FAR;
        else if (t_val < set_point - 16'(bhrc_pkg::OFFSET_HOLD))
            band_sel = bhrc_pkg::BAND_NEAR;
        else
            band_sel = bhrc_pkg::BAND_HOLD;

        unique case (band_sel)
            bhrc_pkg::BAND_FAR:  period = cfg.far_period;
            bhrc_pkg::BAND_NEAR: period = cfg.near_period;
            default:             period = cfg.hold_period;
        endcase
        check_due = elapsed > bhrc_pkg::TIME_W'(period);

        relay_next      = relay_reg;
        prev_temp_next  = prev_temp_reg;
        last_check_next = last_check_reg;
        unique case (band_sel)
            bhrc_pkg::BAND_ABOVE: relay_next = 1'b0;
            bhrc_pkg::BAND_COLD:  relay_next = 1'b1;
            default:
            begin
                // Timed check: turn on unless it rose by a full degree
                if (check_due)
                begin
                    relay_next      = rise < 17'(bhrc_pkg::RISE_MIN);
                    prev_temp_next  = t_val;
                    last_check_next = temp_beat.now;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_reg        <= 1'b0;
            prev_temp_reg    <= bhrc_pkg::TEMP_RESET;
            last_check_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= temp_valid;
            if (temp_valid)
            begin
                relay_reg      <= relay_next;
                prev_temp_reg  <= prev_temp_next;
                last_check_reg <= last_check_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && temp_valid)
        begin
            band_reg <= band_sel;
            temp_reg <= t_val[bhrc_pkg::TEMP_W-1:0];
        end
    end

    assign result_valid = result_valid_reg;
    assign relay_on     = relay_reg;
    assign band         = band_reg;
    assign temperature  = temp_reg;

endmodule

FILE: design/banded_heater_relay_control_core.sv
// ----------------------------------------------------------------------------
// banded_heater_relay_control_core: averaged-temperature heater relay control
// Moving average of sensor samples, conversion to 1/64 degC, and banded
// relay switching with rate-checked decisions near the set point.
// ----------------------------------------------------------------------------
// The core takes one sample beat per clock while sample_stall is low and
// returns one result beat per sample, in order, through the ring RAM read,
// running-sum update, scale and offset, reciprocal multiply and band decision.
// The whole pipeline advances together: it holds whenever a result beat waits
// on result_stall, and sample_stall is high exactly then. The 16-entry sample
// ring lives in a one-read, one-write RAM; entries never written read as zero
// through per-entry fill flags, so there is no clearing pass after reset.
// Register writes are always accepted (cfg_ready is tied high) and must be
// issued while the core is empty; a target write outside 20..80 degC
// (exclusive, in 1/64 degC) is dropped.
module banded_heater_relay_control_core (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic [bhrc_pkg::SAMPLE_W-1:0]     adc_sample,
    input  logic [bhrc_pkg::TIME_W-1:0]       now_ms,

    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              relay_on,
    output logic [2:0]                        band,
    output logic [bhrc_pkg::TEMP_W-1:0]       temperature,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bhrc_pkg::INDEX_W-1:0]      cfg_index,
    input  logic [bhrc_pkg::CFG_W-1:0]        cfg_data
);

    logic                          advance;
    logic                          accept;
    logic                          avg_valid;
    bhrc_pkg::avg_beat_t           avg_beat;
    logic                          temp_valid;
    bhrc_pkg::temp_beat_t          temp_beat;

    logic [bhrc_pkg::TARGET_W-1:0] target_reg;
    logic [bhrc_pkg::PERIOD_W-1:0] far_period_reg;
    logic [bhrc_pkg::PERIOD_W-1:0] near_period_reg;
    logic [bhrc_pkg::PERIOD_W-1:0] hold_period_reg;
    logic [bhrc_pkg::TARGET_W-1:0] target_wr;
    logic                          target_ok;
    bhrc_pkg::cfg_t                cfg;

    // Advance every stage unless the result beat is held downstream
    assign advance      = !(result_valid && result_stall);
    assign accept       = sample_valid && advance;
    assign sample_stall = !advance;
    assign cfg_ready    = 1'b1;

    // Target window check on the low 13 bits of the write data
    assign target_wr = cfg_data[bhrc_pkg::TARGET_W-1:0];
    assign target_ok = (target_wr > bhrc_pkg::TARGET_W'(bhrc_pkg::TARGET_LOW))
                    && (target_wr < bhrc_pkg::TARGET_W'(bhrc_pkg::TARGET_HIGH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg      <= '0;
            far_period_reg  <= bhrc_pkg::FAR_PERIOD_RESET;
            near_period_reg <= bhrc_pkg::NEAR_PERIOD_RESET;
            hold_period_reg <= bhrc_pkg::HOLD_PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bhrc_pkg::cfg_reg_t'(cfg_index))
                bhrc_pkg::REG_TARGET:
                begin
                    if (target_ok)
                        target_reg <= target_wr;
                end
                bhrc_pkg::REG_FAR:  far_period_reg  <= cfg_data;
                bhrc_pkg::REG_NEAR: near_period_reg <= cfg_data;
                bhrc_pkg::REG_HOLD: hold_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.target      = target_reg;
    assign cfg.far_period  = far_period_reg;
    assign cfg.near_period = near_period_reg;
    assign cfg.hold_period = hold_period_reg;

    // Ring RAM and running sum
    bhrc_avg u_avg (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .accept     (accept),
        .adc_sample (adc_sample),
        .now_ms     (now_ms),
        .avg_valid  (avg_valid),
        .avg_beat   (avg_beat)
    );

    // Average to signed 1/64 degC
    bhrc_conv u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .avg_valid  (avg_valid),
        .avg_beat   (avg_beat),
        .temp_valid (temp_valid),
        .temp_beat  (temp_beat)
    );

    // Bands, timed check and the result register
    bhrc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .temp_valid   (temp_valid),
        .temp_beat    (temp_beat),
        .cfg          (cfg),
        .result_valid (result_valid),
        .relay_on     (relay_on),
        .band         (band),
        .temperature  (temperature)
    );

    // At or above target the relay is always off
    a_above_off: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (band == 3'(bhrc_pkg::BAND_ABOVE)) |-> !relay_on)
        else $error("relay on while at or above target");

    // Far below target the relay is always on
    a_cold_on: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (band == 3'(bhrc_pkg::BAND_COLD)) |-> relay_on)
        else $error("relay off while far below target");

    // Converted temperature never falls below the zero-reading value
    a_temp_floor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($signed(temperature) >= -15'sd1312))
        else $error("temperature below conversion floor");

    // The relay only changes when a result beat is delivered
    a_relay_moves_with_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(relay_on) |-> $past(advance) && $past(temp_valid))
        else $error("relay changed without a result beat");

endmodule

FILE: tb/bhrc_relay_checker.sv
// ----------------------------------------------------------------------------
// bhrc_relay_checker: result predictor and scoreboard for the relay core
// Watches the sample, result and register channels, keeps a private copy of
// the averager, converter and band logic, and compares every result beat.
// ----------------------------------------------------------------------------
module bhrc_relay_checker (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          sample_valid,
    input  logic                          sample_stall,
    input  logic [bhrc_pkg::SAMPLE_W-1:0] adc_sample,
    input  logic [bhrc_pkg::TIME_W-1:0]   now_ms,

    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic                          relay_on,
    input  logic [2:0]                    band,
    input  logic [bhrc_pkg::TEMP_W-1:0]   temperature,

    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [bhrc_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [bhrc_pkg::CFG_W-1:0]    cfg_data,

    output int                            fail_count,
    output int                            results_seen,
    output int                            results_due,
    output logic [4:0]                    bands_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import bhrc_pkg::*;

    typedef struct {
        logic              relay;
        band_t             band;
        logic [TEMP_W-1:0] temp;
    } relay_result_t;

    relay_result_t pending_results[$];

    // Private controller state
    logic [SAMPLE_W-1:0] ring [AVERAGE_DEPTH];
    logic [SUM_W-1:0]    sum;
    logic [SLOT_W-1:0]   slot;
    int                  prev_temp;
    logic [TIME_W-1:0]   last_check;
    logic                relay;

    // Register mirror
    logic [TARGET_W-1:0] target;
    logic [PERIOD_W-1:0] far_period;
    logic [PERIOD_W-1:0] near_period;
    logic [PERIOD_W-1:0] hold_period;

    function automatic int avg_to_temp(input logic [SAMPLE_W-1:0] avg);
        longint scaled;
        scaled = (longint'(avg) * ADC_SCALE - ADC_OFFSET) * (longint'(1) << CONV_PRE);
        return int'(scaled / CONV_DIV);
    endfunction

    task automatic apply_reg_write(input logic [INDEX_W-1:0] idx,
                                   input logic [CFG_W-1:0] data);
        logic [TARGET_W-1:0] tgt;
        tgt = data[TARGET_W-1:0];
        case (cfg_reg_t'(idx))
            REG_TARGET: if (tgt > TARGET_LOW && tgt < TARGET_HIGH) target = tgt;
            REG_FAR:    far_period  = data[PERIOD_W-1:0];
            REG_NEAR:   near_period = data[PERIOD_W-1:0];
            REG_HOLD:   hold_period = data[PERIOD_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic predict_relay_step(input logic [SAMPLE_W-1:0] smp,
                                      input logic [TIME_W-1:0] now);
        relay_result_t       r;
        int                  t;
        int                  tgt;
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   elapsed;
        sum       = sum - ring[slot] + smp;
        ring[slot] = smp;
        slot      = (slot == SLOT_W'(AVERAGE_DEPTH - 1)) ? '0 : slot + 1'b1;
        t         = avg_to_temp(SAMPLE_W'(sum >> AVG_SHIFT));
        tgt       = int'(target);
        period    = hold_period;
        if (t >= tgt) begin
            r.band = BAND_ABOVE;
            relay  = 1'b0;
        end else if (t < tgt - OFFSET_FAR) begin
            r.band = BAND_COLD;
            relay  = 1'b1;
        end else begin
            if (t < tgt - OFFSET_NEAR) begin
                r.band = BAND_FAR;
                period = far_period;
            end else if (t < tgt - OFFSET_HOLD) begin
                r.band = BAND_NEAR;
                period = near_period;
            end else begin
                r.band = BAND_HOLD;
            end
            // elapsed time wraps modulo 2^32
            elapsed = now - last_check;
            if (elapsed > TIME_W'(period)) begin
                relay      = (t - prev_temp) < RISE_MIN;
                prev_temp  = t;
                last_check = now;
            end
        end
        r.relay = relay;
        r.temp  = t[TEMP_W-1:0];
        pending_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n) begin
        relay_result_t want;
        int            errs;
        if (!rst_n) begin
            foreach (ring[i]) ring[i] = '0;
            sum         = '0;
            slot        = '0;
            prev_temp   = avg_to_temp('0);
            last_check  = '0;
            relay       = 1'b0;
            target      = '0;
            far_period  = FAR_PERIOD_RESET;
            near_period = NEAR_PERIOD_RESET;
            hold_period = HOLD_PERIOD_RESET;
            pending_results.delete();
            fail_count   <= 0;
            results_seen <= 0;
            results_due  <= 0;
            bands_seen   <= '0;
        end else begin
            errs = 0;
            if (cfg_valid && cfg_ready)
                apply_reg_write(cfg_index, cfg_data);
            if (result_valid && !result_stall) begin
                results_seen <= results_seen + 1;
                if (pending_results.size() == 0) begin
                    $error("result beat with no sample outstanding");
                    errs++;
                end else begin
                    want = pending_results.pop_front();
                    if (relay_on !== want.relay) begin
                        $error("relay_on: expected %0d, got %0d", want.relay, relay_on);
                        errs++;
                    end
                    if (band !== want.band) begin
                        $error("band: expected %0d, got %0d", want.band, band);
                        errs++;
                    end
                    if (temperature !== want.temp) begin
                        $error("temperature: expected %0d, got %0d",
                               $signed(want.temp), $signed(temperature));
                        errs++;
                    end
                    bands_seen <= bands_seen | (5'b1 << want.band);
                end
            end
            if (sample_valid && !sample_stall)
                predict_relay_step(adc_sample, now_ms);
            fail_count  <= fail_count + errs;
            results_due <= pending_results.size();
        end
    end

endmodule

FILE: tb/tb_banded_heater_relay_control_core.sv
// ----------------------------------------------------------------------------
// tb_banded_heater_relay_control_core: testbench top for the relay core
// Drives sensor sample beats and register writes, randomizes stalls on both
// channels, and leaves prediction and comparison to the checker beside it.
// ----------------------------------------------------------------------------
module tb_banded_heater_relay_control_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bhrc_pkg::*;

    // Pipeline is five deep; SETTLE_CYCLES lets it settle before idle work
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 400000;

    logic                clk;
    logic                rst_n;
    logic                sample_valid;
    logic                sample_stall;
    logic [SAMPLE_W-1:0] adc_sample;
    logic [TIME_W-1:0]   now_ms;
    logic                result_valid;
    logic                result_stall;
    logic                relay_on;
    logic [2:0]          band;
    logic [TEMP_W-1:0]   temperature;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [INDEX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    int         fail_count;
    int         results_seen;
    int         results_due;
    logic [4:0] bands_seen;

    int                send_idle_pct;
    int                recv_idle_pct;
    int                beats_sent  = 0;
    int                reg_writes  = 0;
    int                cycle_count = 0;
    logic [TIME_W-1:0] clock_ms;

    banded_heater_relay_control_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .adc_sample   (adc_sample),
        .now_ms       (now_ms),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .relay_on     (relay_on),
        .band         (band),
        .temperature  (temperature),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bhrc_relay_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .adc_sample   (adc_sample),
        .now_ms       (now_ms),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .relay_on     (relay_on),
        .band         (band),
        .temperature  (temperature),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .results_seen (results_seen),
        .results_due  (results_due),
        .bands_seen   (bands_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Back-pressure on the result side; the idle percentage changes by phase
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Guard against a hung handshake
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_banded_heater_relay_control_core: done, errors");
        $finish;
    end

    // Map a set point back to the raw average that sits on it, so that the
    // random samples hover around the target instead of far below or above.
    function automatic int level_for(input int tgt);
        return (tgt * CONV_DIV / (1 << CONV_PRE) + ADC_OFFSET) / ADC_SCALE;
    endfunction

    // Offer one sample beat, with random idle cycles ahead of it. Hold the
    // payload until the core takes it; valid stays high between back-to-back
    // beats so that it never drops and rises within one step.
    task automatic send_beat(input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        adc_sample   <= smp;
        now_ms       <= t;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // Raise one register write and hold it until taken; the caller drops valid.
    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_writes++;
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] tgt, input logic [CFG_W-1:0] far_ms,
                                input logic [CFG_W-1:0] near_ms,
                                input logic [CFG_W-1:0] hold_ms);
        cfg_write(REG_TARGET, tgt);
        cfg_write(REG_FAR, far_ms);
        cfg_write(REG_NEAR, near_ms);
        cfg_write(REG_HOLD, hold_ms);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait until every sample beat has its result back, then
    // let the pipeline settle so that the core is empty for a register write.
    task automatic drain();
        sample_valid <= 1'b0;
        while (results_seen < beats_sent)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random samples around a drifting level near the set point. The level
    // wanders a few counts at a time and now and then drops far below, so
    // the average sweeps through every band and rises between checks. A few
    // beats are full-range noise, and time now and then jumps anywhere.
    task automatic run_random(input int count, input int step_max, input int tgt);
        int base;
        int level;
        int smp;
        base  = level_for(tgt);
        level = base - 20;
        repeat (count)
        begin
            if ($urandom_range(0, 7) == 0)
                level = level + int'($urandom_range(0, 6)) - 3;
            if ($urandom_range(0, 39) == 0)
                level = base - 45;
            if (level < base - 55)
                level = base - 55;
            if (level > base + 8)
                level = base + 8;
            if ($urandom_range(0, 99) < 8)
                smp = int'($urandom_range(0, 1023));
            else
                smp = level + int'($urandom_range(0, 12)) - 6;
            if (smp < 0)
                smp = 0;
            if (smp > 1023)
                smp = 1023;
            if ($urandom_range(0, 99) == 0)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + $urandom_range(0, step_max);
            send_beat(smp[SAMPLE_W-1:0], clock_ms);
        end
    endtask

    initial
    begin
        int tgt;
        int base;
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        adc_sample   <= '0;
        now_ms       <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_TARGET;
        cfg_data     <= '0;
        clock_ms      = '0;
        send_idle_pct = 22;
        recv_idle_pct = 68;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: extremes of both fields, alternating bit patterns
        send_beat(10'h000, 32'h0000_0000);
        send_beat(10'h3FF, 32'hFFFF_FFFF);
        send_beat(10'h155, 32'hAAAA_AAAA);
        send_beat(10'h2AA, 32'h5555_5555);
        drain();

        // Out-of-range set points are dropped, including both edges and a
        // value with every bit set; the last write has spare top bits that
        // fall outside the target field and must be masked.
        cfg_write(REG_TARGET, 16'd1280);
        cfg_write(REG_TARGET, 16'd5120);
        cfg_write(REG_TARGET, 16'hFFFF);
        program_regs(16'h2000 | 16'd3000, 16'd0, 16'd0, 16'd0);

        // Walk the average from cold through the near bands to above target;
        // one beat repeats its time so the zero-period check does not fire.
        base     = level_for(3000);
        clock_ms = 32'd100;
        repeat (6)
        begin
            clock_ms++;
            send_beat(SAMPLE_W'(base - 60), clock_ms);
        end
        repeat (6)
        begin
            clock_ms++;
            send_beat(SAMPLE_W'(base), clock_ms);
        end
        send_beat(SAMPLE_W'(base), clock_ms);
        repeat (4)
        begin
            clock_ms++;
            send_beat(SAMPLE_W'(base + 40), clock_ms);
        end
        drain();

        // Lowest valid set point, every period zero: a check whenever time has moved on
        program_regs(16'd1281, 16'd0, 16'd0, 16'd0);
        run_random(300, 4, 1281);
        drain();

        // Highest valid set point, longest periods, time wrapping past zero
        program_regs(16'd5119, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        clock_ms = 32'hFFFF_0000;
        run_random(300, 40000, 5119);
        drain();

        // Swap the idle pattern: sender mostly idle, receiver mostly ready
        send_idle_pct = 68;
        recv_idle_pct = 22;
        program_regs(16'd3000, 16'd300, 16'd200, 16'd100);
        run_random(300, 60, 3000);
        drain();

        tgt = int'($urandom_range(1281, 5119));
        cfg_write(REG_TARGET, CFG_W'($urandom_range(0, 1280)));
        program_regs(CFG_W'(tgt), CFG_W'($urandom_range(0, 3000)),
                     CFG_W'($urandom_range(0, 3000)), CFG_W'($urandom_range(0, 3000)));
        run_random(300, 100, tgt);
        drain();

        // No idling on either side from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_regs(16'd2000, CFG_W'($urandom_range(0, 65535)),
                     CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)));
        run_random(330, 30000, 2000);
        drain();

        tgt = int'($urandom_range(1281, 5119));
        cfg_write(REG_TARGET, CFG_W'($urandom_range(5120, 65535)));
        program_regs(CFG_W'(tgt), CFG_W'($urandom_range(0, 1000)),
                     CFG_W'($urandom_range(0, 1000)), CFG_W'($urandom_range(0, 1000)));
        run_random(300, 200, tgt);
        drain();

        $display("Covered %0d sample beats and %0d register writes over eight settings,",
                 beats_sent, reg_writes);
        $display("with time wrap and jumps; %0d result beats checked, bands hit (4..0) %b",
                 results_seen, bands_seen);
        if (fail_count == 0 && results_due == 0)
            $display("tb_banded_heater_relay_control_core: done, clean");
        else
            $display("tb_banded_heater_relay_control_core: done, errors");
        $finish;
    end

endmodule
